// File: rtl/core/lhge_pkg.sv
package lhge_pkg;

  localparam int PIX_W       = 8;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int ROW_W       = 11;
  localparam int ROW_LIMIT   = 2048;
  localparam int OUT_W       = 48;
  localparam int OUT_TDATA_W = 3 * OUT_W;

  localparam int WIDTH_RST  = 1920;
  localparam int HEIGHT_RST = 1080;

  // Signed difference widths and the widths of their squares.
  localparam int HP_W      = 12;
  localparam int EDGE_W    = 11;
  localparam int HP_SQ_W   = 22;
  localparam int EDGE_SQ_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;

  // win[row][col]: row 0 is the oldest line, col 2 the newest column.
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic vld;
    logic eval;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic [OUT_W-1:0] vertical;
    logic [OUT_W-1:0] horizontal;
    logic [OUT_W-1:0] highpass;
  } result_t;

endpackage

// File: rtl/core/lhge_line_win.sv
module lhge_line_win #(
  parameter int MAX_LINE_WIDTH = 2048
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lhge_pkg::ctl_t                    acc_ctl,
  input  logic [$clog2(MAX_LINE_WIDTH)-1:0] acc_idx,
  input  lhge_pkg::pix_t                    acc_pix,
  output lhge_pkg::ctl_t                    s1_ctl,
  output lhge_pkg::ctl_t                    s2_ctl,
  output lhge_pkg::win_t                    win
);
  import lhge_pkg::*;

  localparam int AW = $clog2(MAX_LINE_WIDTH);

  pix_t upper_mem [MAX_LINE_WIDTH];
  pix_t middle_mem [MAX_LINE_WIDTH];

  pix_t          up_q_r;
  pix_t          mid_q_r;
  ctl_t          s1_ctl_r;
  ctl_t          s2_ctl_r;
  logic [AW-1:0] s1_idx_r;
  pix_t          s1_pix_r;
  win_t          win_r;

  always_ff @(posedge clk) begin
    if (acc_ctl.vld) begin
      up_q_r  <= upper_mem[acc_idx];
      mid_q_r <= middle_mem[acc_idx];
    end
  end

  // Same column is revisited no sooner than three beats later, so the
  // write below never collides with a pending read.
  always_ff @(posedge clk) begin
    if (s1_ctl_r.vld) begin
      upper_mem[s1_idx_r]  <= mid_q_r;
      middle_mem[s1_idx_r] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
    end else begin
      s1_ctl_r <= acc_ctl;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_ctl.vld) begin
      s1_idx_r <= acc_idx;
      s1_pix_r <= acc_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ctl_r.vld) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= up_q_r;
      win_r[1][2] <= mid_q_r;
      win_r[2][2] <= s1_pix_r;
    end
  end

  assign s1_ctl = s1_ctl_r;
  assign s2_ctl = s2_ctl_r;
  assign win    = win_r;

endmodule

// File: rtl/core/luma_highpass_gradient_energy.sv
// Luma high-pass and gradient energy. Takes one 8-bit pixel per beat in raster
// order and accepts a pixel every clock but holds a frame's last pixel off
// while two results are already queued or in flight. Border pixels count as
// zero. Two line memories of MAX_LINE_WIDTH bytes with a registered read feed
// a 3x3 window, and three squared terms (eight-neighbour high-pass, top minus
// bottom rows, left minus right columns) are summed per frame with saturation
// at SUM_WIDTH bits. The three sums leave as one beat once the last pixel of
// a frame has passed the window, difference and square registers, and the sums
// restart at zero. Up to two results are queued at the output. Frame width and
// height are written on the cfg port between frames by the user; not enforced.
module luma_highpass_gradient_energy #(
  parameter int MAX_LINE_WIDTH = 2048,
  parameter int SUM_WIDTH      = 48
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lhge_pkg::PIX_W-1:0]          in_tdata,   // [7:0] pixel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [47:0] highpass_energy, [95:48] horizontal_energy, [143:96] vertical_energy
  output logic [lhge_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lhge_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lhge_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lhge_pkg::*;

  localparam int COL_W     = $clog2(MAX_LINE_WIDTH);
  localparam int WRST_CLMP = (WIDTH_RST > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : WIDTH_RST;
  localparam logic [COL_W-1:0] LAST_COL_RST = COL_W'(WRST_CLMP - 1);
  localparam logic [ROW_W-1:0] LAST_ROW_RST = ROW_W'(HEIGHT_RST - 1);

  // ---------------- configuration ----------------
  logic [COL_W-1:0] last_col_r, last_col_nxt;
  logic [ROW_W-1:0] last_row_r, last_row_nxt;
  logic             cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    last_col_nxt = last_col_r;
    last_row_nxt = last_row_r;
    if (cfg_wr) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH: begin
          if (cfg_data < CFG_DATA_W'(3)) begin
            last_col_nxt = COL_W'(2);
          end else if (32'(cfg_data) > 32'(MAX_LINE_WIDTH)) begin
            last_col_nxt = COL_W'(MAX_LINE_WIDTH - 1);
          end else begin
            last_col_nxt = COL_W'(cfg_data - CFG_DATA_W'(1));
          end
        end
        CFG_FRAME_HEIGHT: begin
          if (cfg_data < CFG_DATA_W'(3)) begin
            last_row_nxt = ROW_W'(2);
          end else if (32'(cfg_data) > 32'(ROW_LIMIT)) begin
            last_row_nxt = ROW_W'(ROW_LIMIT - 1);
          end else begin
            last_row_nxt = ROW_W'(cfg_data - CFG_DATA_W'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= LAST_COL_RST;
      last_row_r <= LAST_ROW_RST;
    end else begin
      last_col_r <= last_col_nxt;
      last_row_r <= last_row_nxt;
    end
  end

  // ---------------- position and accept ----------------
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             line_end, cur_last, cur_eval, cur_border;
  logic             accept, pipe_last;
  logic [1:0]       q_cnt_r;
  ctl_t             acc_ctl, s1_ctl, s2_ctl;
  pix_t             acc_pix;
  win_t             win;

  assign line_end   = col_r >= last_col_r;
  assign cur_last   = line_end && (row_r >= last_row_r);
  assign cur_eval   = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
  assign cur_border = (row_r == '0) || (row_r >= last_row_r) || (col_r == '0) || line_end;

  always_comb begin
    in_tready = 1'b1;
    if (cur_last && ((q_cnt_r == 2'd2) || ((q_cnt_r == 2'd1) && pipe_last))) begin
      in_tready = 1'b0;
    end
  end

  assign accept  = in_tvalid && in_tready;
  assign acc_pix = cur_border ? '0 : in_tdata;

  always_comb begin
    acc_ctl.vld  = accept;
    acc_ctl.eval = cur_eval;
    acc_ctl.last = cur_last;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (line_end) begin
        col_nxt = '0;
        row_nxt = cur_last ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  lhge_line_win #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_line_win (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc_ctl (acc_ctl),
    .acc_idx (col_r),
    .acc_pix (acc_pix),
    .s1_ctl  (s1_ctl),
    .s2_ctl  (s2_ctl),
    .win     (win)
  );

  // ---------------- window differences ----------------
  logic [9:0]                top_sum, bot_sum, left_sum, right_sum;
  logic [10:0]               nbr_sum;
  logic signed [HP_W:0]      hp_full;
  logic signed [EDGE_W-1:0]  hz_diff, vt_diff;
  ctl_t                      s3_ctl_r, s4_ctl_r;
  logic signed [HP_W-1:0]    s3_hp_r;
  logic signed [EDGE_W-1:0]  s3_hz_r, s3_vt_r;

  assign top_sum   = 10'(win[0][0]) + 10'(win[0][1]) + 10'(win[0][2]);
  assign bot_sum   = 10'(win[2][0]) + 10'(win[2][1]) + 10'(win[2][2]);
  assign left_sum  = 10'(win[0][0]) + 10'(win[1][0]) + 10'(win[2][0]);
  assign right_sum = 10'(win[0][2]) + 10'(win[1][2]) + 10'(win[2][2]);
  assign nbr_sum   = 11'(top_sum) + 11'(bot_sum) + 11'(win[1][0]) + 11'(win[1][2]);
  assign hp_full   = $signed({2'b00, win[1][1], 3'b000}) - $signed({2'b00, nbr_sum});
  assign hz_diff   = $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});
  assign vt_diff   = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});

  always_ff @(posedge clk) begin
    s3_hp_r <= hp_full[HP_W-1:0];
    s3_hz_r <= hz_diff;
    s3_vt_r <= vt_diff;
  end

  // ---------------- squares ----------------
  logic signed [2*HP_W-1:0]   hp_prod;
  logic signed [2*EDGE_W-1:0] hz_prod, vt_prod;
  logic [HP_SQ_W-1:0]         s4_hp_r;
  logic [EDGE_SQ_W-1:0]       s4_hz_r, s4_vt_r;

  assign hp_prod = s3_hp_r * s3_hp_r;
  assign hz_prod = s3_hz_r * s3_hz_r;
  assign vt_prod = s3_vt_r * s3_vt_r;

  always_ff @(posedge clk) begin
    s4_hp_r <= hp_prod[HP_SQ_W-1:0];
    s4_hz_r <= hz_prod[EDGE_SQ_W-1:0];
    s4_vt_r <= vt_prod[EDGE_SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
      s4_ctl_r <= '0;
    end else begin
      s3_ctl_r <= s2_ctl;
      s4_ctl_r <= s3_ctl_r;
    end
  end

  assign pipe_last = (s1_ctl.vld && s1_ctl.last) || (s2_ctl.vld && s2_ctl.last) ||
                     (s3_ctl_r.vld && s3_ctl_r.last) || (s4_ctl_r.vld && s4_ctl_r.last);

  // ---------------- saturating accumulation ----------------
  logic [SUM_WIDTH-1:0] hp_sum_r, hz_sum_r, vt_sum_r;
  logic [SUM_WIDTH-1:0] hp_new, hz_new, vt_new;
  logic [SUM_WIDTH:0]   hp_add, hz_add, vt_add;
  logic                 push, pop;
  result_t              res_new;

  assign hp_add = {1'b0, hp_sum_r} + (SUM_WIDTH+1)'(s4_hp_r);
  assign hz_add = {1'b0, hz_sum_r} + (SUM_WIDTH+1)'(s4_hz_r);
  assign vt_add = {1'b0, vt_sum_r} + (SUM_WIDTH+1)'(s4_vt_r);

  always_comb begin
    hp_new = hp_sum_r;
    hz_new = hz_sum_r;
    vt_new = vt_sum_r;
    if (s4_ctl_r.eval) begin
      hp_new = hp_add[SUM_WIDTH] ? '1 : hp_add[SUM_WIDTH-1:0];
      hz_new = hz_add[SUM_WIDTH] ? '1 : hz_add[SUM_WIDTH-1:0];
      vt_new = vt_add[SUM_WIDTH] ? '1 : vt_add[SUM_WIDTH-1:0];
    end
  end

  assign push = s4_ctl_r.vld && s4_ctl_r.last;

  always_comb begin
    res_new.highpass   = OUT_W'(hp_new);
    res_new.horizontal = OUT_W'(hz_new);
    res_new.vertical   = OUT_W'(vt_new);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_sum_r <= '0;
      hz_sum_r <= '0;
      vt_sum_r <= '0;
    end else if (s4_ctl_r.vld) begin
      hp_sum_r <= push ? '0 : hp_new;
      hz_sum_r <= push ? '0 : hz_new;
      vt_sum_r <= push ? '0 : vt_new;
    end
  end

  // ---------------- two-entry result queue ----------------
  logic [OUT_TDATA_W-1:0] q0_r, q0_nxt, q1_r, q1_nxt;
  logic [1:0]             q_cnt_nxt;

  assign pop = out_tvalid && out_tready;

  always_comb begin
    q0_nxt    = q0_r;
    q1_nxt    = q1_r;
    q_cnt_nxt = q_cnt_r;
    case (q_cnt_r)
      2'd0: begin
        if (push) begin
          q0_nxt    = res_new;
          q_cnt_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (pop && push) begin
          q0_nxt = res_new;
        end else if (pop) begin
          q_cnt_nxt = 2'd0;
        end else if (push) begin
          q1_nxt    = res_new;
          q_cnt_nxt = 2'd2;
        end
      end
      default: begin
        if (pop) begin
          q0_nxt = q1_r;
          if (push) begin
            q1_nxt = res_new;
          end else begin
            q_cnt_nxt = 2'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
  end

  assign out_tvalid = q_cnt_r != 2'd0;
  assign out_tdata  = q0_r;

endmodule

// File: rtl/core/lhge_chk.sv
module lhge_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lhge_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             cfg_valid,
  input logic                             cfg_ready
);
  import lhge_pkg::*;

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result still offered after reset");

  // A held result beat keeps its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // The input is only held off while results are backed up at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with an empty result queue");

  // A new result is offered only after an accepted pixel beat has passed the
  // line-window, difference, square and result queue registers.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 5))
    else $error("result appeared without a matching input beat");

  // Configuration writes are never back-pressured.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind luma_highpass_gradient_energy lhge_chk u_lhge_chk (.*);
